// ===== sv/jbl_pkg.sv =====
`timescale 1ns / 1ps

package jbl_pkg;

    // Result kinds, carried on the output tuser.
    typedef enum logic [3:0] {
        K_OBJ_BEGIN = 4'd0,
        K_OBJ_END   = 4'd1,
        K_ARR_BEGIN = 4'd2,
        K_ARR_END   = 4'd3,
        K_COLON     = 4'd4,
        K_COMMA     = 4'd5,
        K_STR_START = 4'd6,
        K_STR_CHAR  = 4'd7,
        K_STR_END   = 4'd8,
        K_NUM_CHAR  = 4'd9,
        K_NUM_END   = 4'd10,
        K_BOOLEAN   = 4'd11,
        K_NULL      = 4'd12,
        K_DOC_END   = 4'd13,
        K_ERROR     = 4'd14
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_STR  = 3'd1,
        M_ESC  = 3'd2,
        M_NUM  = 3'd3,
        M_LIT  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        L_TRUE  = 2'd0,
        L_FALSE = 2'd1,
        L_NULL  = 2'd2
    } t_lit;

    localparam logic [2:0] ERR_START   = 3'd0;
    localparam logic [2:0] ERR_ESCAPE  = 3'd1;
    localparam logic [2:0] ERR_UNTERM  = 3'd2;
    localparam logic [2:0] ERR_NUMBER  = 3'd3;
    localparam logic [2:0] ERR_LITERAL = 3'd4;

    localparam logic [1:0] NK_UNSIGNED = 2'd0;
    localparam logic [1:0] NK_SIGNED   = 2'd1;
    localparam logic [1:0] NK_REAL     = 2'd2;

    // Result queue between the lexer core and the output port.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [1:0]  number_kind;
        logic        bool_value;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] len;
        logic       sign;
        logic       point;
        logic       expo;
        logic [7:0] prev;
        logic       first_zero;
        logic       second_zero;
    } t_num;

    function automatic t_result mk_res(t_kind kind, logic [7:0] data, logic [1:0] nk,
                                       logic bv, logic [2:0] ec);
        t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.number_kind = nk;
        r.bool_value  = bv;
        r.error_code  = ec;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/jbl_core.sv =====
`timescale 1ns / 1ps

module jbl_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [7:0]                    i_byte,
    input  logic                          i_end,
    output jbl_pkg::t_result [1:0]        o_res,
    output logic [1:0]                    o_cnt
);

    typedef struct packed {
        jbl_pkg::t_num st;
        logic          bad;
    } t_num_step;

    jbl_pkg::t_mode r_mode, n_mode;
    jbl_pkg::t_lit  r_sel, n_sel;
    logic [2:0]     r_pos, n_pos;
    jbl_pkg::t_num  r_num, n_num;

    jbl_pkg::t_result [1:0] res;
    logic [1:0]             cnt;

    function automatic logic [7:0] lit_char(jbl_pkg::t_lit sel, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        unique case (sel)
            jbl_pkg::L_TRUE: begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            jbl_pkg::L_FALSE: begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'd0;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(jbl_pkg::t_lit sel);
        return (sel == jbl_pkg::L_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic is_num_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || c == "+" || c == "-" || c == "." ||
               c == "e" || c == "E";
    endfunction

    // One number character: update flags and check for a duplicate point or
    // exponent and for a plus sign that is neither leading nor after an exponent mark.
    function automatic t_num_step num_step(jbl_pkg::t_num st, logic [7:0] c);
        t_num_step r;
        r.st  = st;
        r.bad = 1'b0;
        if (c == "+") begin
            if (st.len == 2'd0) r.st.sign = 1'b1;
            else if (st.prev != "e" && st.prev != "E") r.bad = 1'b1;
        end else if (c == "-") begin
            if (st.len == 2'd0) r.st.sign = 1'b1;
        end else if (c == ".") begin
            r.bad      = st.point;
            r.st.point = 1'b1;
        end else if (c == "e" || c == "E") begin
            r.bad     = st.expo;
            r.st.expo = 1'b1;
        end
        if (st.len == 2'd0) r.st.first_zero  = (c == "0");
        if (st.len == 2'd1) r.st.second_zero = (c == "0");
        if (st.len != 2'd3) r.st.len = st.len + 2'd1;
        r.st.prev = c;
        return r;
    endfunction

    function automatic jbl_pkg::t_result finish_num(jbl_pkg::t_num st);
        logic       bad;
        logic [1:0] nk;
        bad = st.sign ? (st.len <= 2'd1) : (st.len == 2'd0);
        if (!bad && st.point) begin
            nk = jbl_pkg::NK_REAL;
        end else if (st.sign) begin
            if (st.len == 2'd3 && st.second_zero) bad = 1'b1;
            nk = jbl_pkg::NK_SIGNED;
        end else begin
            if (st.len >= 2'd2 && st.first_zero) bad = 1'b1;
            nk = jbl_pkg::NK_UNSIGNED;
        end
        if (bad) return jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                        jbl_pkg::ERR_NUMBER);
        return jbl_pkg::mk_res(jbl_pkg::K_NUM_END, 8'd0, nk, 1'b0, 3'd0);
    endfunction

    always_comb begin
        t_num_step        ns;
        logic             do_start;
        logic [2:0]       np;
        jbl_pkg::t_result tmp;

        n_mode   = r_mode;
        n_sel    = r_sel;
        n_pos    = r_pos;
        n_num    = r_num;
        res      = '0;
        cnt      = 2'd0;
        do_start = 1'b0;
        ns       = '0;
        np       = 3'd0;
        tmp      = '0;

        if (i_end) begin
            unique case (r_mode)
                jbl_pkg::M_STR, jbl_pkg::M_ESC: begin
                    res[0] = jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                             jbl_pkg::ERR_UNTERM);
                    cnt = 2'd1;
                end
                jbl_pkg::M_NUM: begin
                    res[0] = finish_num(r_num);
                    n_num  = '0;
                    cnt    = 2'd1;
                end
                jbl_pkg::M_LIT: begin
                    res[0] = jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                             jbl_pkg::ERR_LITERAL);
                    cnt = 2'd1;
                end
                default: ;
            endcase
            res[cnt[0]] = jbl_pkg::mk_res(jbl_pkg::K_DOC_END, 8'd0, 2'd0, 1'b0, 3'd0);
            cnt    = cnt + 2'd1;
            n_mode = jbl_pkg::M_IDLE;
            n_pos  = 3'd0;
        end else begin
            unique case (r_mode)
                jbl_pkg::M_STR: begin
                    if (i_byte == "\\") begin
                        n_mode = jbl_pkg::M_ESC;
                    end else if (i_byte == "\"") begin
                        n_mode = jbl_pkg::M_IDLE;
                        res[0] = jbl_pkg::mk_res(jbl_pkg::K_STR_END, 8'd0, 2'd0, 1'b0,
                                                 3'd0);
                        cnt    = 2'd1;
                    end else begin
                        res[0] = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR, i_byte, 2'd0, 1'b0,
                                                 3'd0);
                        cnt    = 2'd1;
                    end
                end
                jbl_pkg::M_ESC: begin
                    n_mode = jbl_pkg::M_STR;
                    cnt    = 2'd1;
                    unique case (i_byte) inside
                        "\"", "\\", "/": tmp = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR,
                                                               i_byte, 2'd0, 1'b0, 3'd0);
                        "b": tmp = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR, 8'd8, 2'd0,
                                                   1'b0, 3'd0);
                        "f": tmp = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR, 8'd12, 2'd0,
                                                   1'b0, 3'd0);
                        "n": tmp = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR, 8'd10, 2'd0,
                                                   1'b0, 3'd0);
                        "r": tmp = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR, 8'd13, 2'd0,
                                                   1'b0, 3'd0);
                        "t": tmp = jbl_pkg::mk_res(jbl_pkg::K_STR_CHAR, 8'd9, 2'd0,
                                                   1'b0, 3'd0);
                        // The hex digits of a unicode escape pass as plain bytes.
                        "u": cnt = 2'd0;
                        default: begin
                            n_mode = jbl_pkg::M_IDLE;
                            tmp    = jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                                     jbl_pkg::ERR_ESCAPE);
                        end
                    endcase
                    res[0] = tmp;
                end
                jbl_pkg::M_NUM: begin
                    if (is_num_char(i_byte)) begin
                        ns = num_step(r_num, i_byte);
                        if (ns.bad) begin
                            n_num  = '0;
                            n_mode = jbl_pkg::M_IDLE;
                            res[0] = jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                                     jbl_pkg::ERR_NUMBER);
                        end else begin
                            n_num  = ns.st;
                            res[0] = jbl_pkg::mk_res(jbl_pkg::K_NUM_CHAR, i_byte, 2'd0,
                                                     1'b0, 3'd0);
                        end
                        cnt = 2'd1;
                    end else begin
                        // The delimiter that ends a number starts the next token.
                        res[0]   = finish_num(r_num);
                        n_num    = '0;
                        cnt      = 2'd1;
                        do_start = 1'b1;
                    end
                end
                jbl_pkg::M_LIT: begin
                    np = r_pos + 3'd1;
                    cnt = 2'd1;
                    if (r_pos >= lit_len(r_sel) || lit_char(r_sel, r_pos) != i_byte) begin
                        n_mode = jbl_pkg::M_IDLE;
                        n_pos  = 3'd0;
                        res[0] = jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                                 jbl_pkg::ERR_LITERAL);
                    end else if (np == lit_len(r_sel)) begin
                        n_mode = jbl_pkg::M_IDLE;
                        n_pos  = 3'd0;
                        if (r_sel == jbl_pkg::L_TRUE || r_sel == jbl_pkg::L_FALSE)
                            res[0] = jbl_pkg::mk_res(jbl_pkg::K_BOOLEAN, 8'd0, 2'd0,
                                                     r_sel == jbl_pkg::L_TRUE, 3'd0);
                        else
                            res[0] = jbl_pkg::mk_res(jbl_pkg::K_NULL, 8'd0, 2'd0, 1'b0,
                                                     3'd0);
                    end else begin
                        n_pos = np;
                        cnt   = 2'd0;
                    end
                end
                default: do_start = 1'b1;
            endcase

            if (do_start) begin
                n_mode = jbl_pkg::M_IDLE;
                tmp    = '0;
                unique case (i_byte) inside
                    " ", "\t", "\n", "\r": ;
                    "{": tmp = jbl_pkg::mk_res(jbl_pkg::K_OBJ_BEGIN, 8'd0, 2'd0, 1'b0,
                                               3'd0);
                    "}": tmp = jbl_pkg::mk_res(jbl_pkg::K_OBJ_END, 8'd0, 2'd0, 1'b0,
                                               3'd0);
                    "[": tmp = jbl_pkg::mk_res(jbl_pkg::K_ARR_BEGIN, 8'd0, 2'd0, 1'b0,
                                               3'd0);
                    "]": tmp = jbl_pkg::mk_res(jbl_pkg::K_ARR_END, 8'd0, 2'd0, 1'b0,
                                               3'd0);
                    ":": tmp = jbl_pkg::mk_res(jbl_pkg::K_COLON, 8'd0, 2'd0, 1'b0, 3'd0);
                    ",": tmp = jbl_pkg::mk_res(jbl_pkg::K_COMMA, 8'd0, 2'd0, 1'b0, 3'd0);
                    "\"": begin
                        n_mode = jbl_pkg::M_STR;
                        tmp    = jbl_pkg::mk_res(jbl_pkg::K_STR_START, 8'd0, 2'd0, 1'b0,
                                                 3'd0);
                    end
                    "t", "f", "n": begin
                        n_mode = jbl_pkg::M_LIT;
                        n_pos  = 3'd1;
                        n_sel  = (i_byte == "t") ? jbl_pkg::L_TRUE :
                                 (i_byte == "f") ? jbl_pkg::L_FALSE : jbl_pkg::L_NULL;
                    end
                    "-", ["0":"9"]: begin
                        ns     = num_step('0, i_byte);
                        n_num  = ns.st;
                        n_mode = jbl_pkg::M_NUM;
                        tmp    = jbl_pkg::mk_res(jbl_pkg::K_NUM_CHAR, i_byte, 2'd0, 1'b0,
                                                 3'd0);
                    end
                    default: tmp = jbl_pkg::mk_res(jbl_pkg::K_ERROR, 8'd0, 2'd0, 1'b0,
                                                   jbl_pkg::ERR_START);
                endcase
                // Whitespace and literal starts give no result.
                if (!(i_byte == " " || i_byte == "\t" || i_byte == "\n" ||
                      i_byte == "\r" || i_byte == "t" || i_byte == "f" ||
                      i_byte == "n")) begin
                    res[cnt[0]] = tmp;
                    cnt         = cnt + 2'd1;
                end
            end
        end

        if (cnt == 2'd2) res[1].last = 1'b1;
        else if (cnt == 2'd1) res[0].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jbl_pkg::M_IDLE;
            r_sel  <= jbl_pkg::L_TRUE;
            r_pos  <= 3'd0;
            r_num  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_sel  <= n_sel;
            r_pos  <= n_pos;
            r_num  <= n_num;
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

endmodule

// ===== sv/jbl_res_fifo.sv =====
`timescale 1ns / 1ps

module jbl_res_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [1:0]                     i_push_cnt,
    input  jbl_pkg::t_result [1:0]         i_res,
    output logic                           o_valid,
    input  logic                           i_ready,
    output jbl_pkg::t_result               o_res,
    output logic [jbl_pkg::RQ_CW-1:0]      o_count
);

    jbl_pkg::t_result                 r_mem [jbl_pkg::RQ_DEPTH];
    logic [jbl_pkg::RQ_AW-1:0]        r_wptr, r_rptr;
    logic [jbl_pkg::RQ_CW-1:0]        r_count;
    logic                             pop;
    logic [jbl_pkg::RQ_AW-1:0]        wptr1;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rptr];
    assign o_count = r_count;
    assign wptr1   = r_wptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wptr] <= i_res[0];
        if (i_push_cnt == 2'd2) r_mem[wptr1]  <= i_res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + jbl_pkg::RQ_AW'(i_push_cnt);
            if (pop) r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + jbl_pkg::RQ_CW'(i_push_cnt) - jbl_pkg::RQ_CW'(pop);
        end
    end

endmodule

// ===== sv/json_byte_lexer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Group    tdata                          tuser           tlast
// -------   ------   ----------------------------   -------------   -----------
// input     s_axis   [7:0] in_byte                  end_mark        (none)
// output    m_axis   [7:0] data_byte, [9:8] number   [3:0] kind      last result
//                    kind, [10] bool, [13:11] error                  of the byte
//
// A byte is taken into the input register and classified from there when the
// four-entry result queue has room; its zero, one or two results are written
// to the queue. One byte per cycle is sustained while each byte gives at most
// one result and the output is ready; a byte with two results places both on
// the output in turn. The input stalls when the queue holds more than two
// results. Reset clears the lexer state, the input valid flag and the queue.

module json_byte_lexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] end_mark
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] number_kind,
                                        // [10] bool_value, [13:11] error_code
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    output logic        m_axis_tlast
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_end;
    logic                         fire;
    jbl_pkg::t_result [1:0]       core_res;
    logic [1:0]                   core_cnt;
    jbl_pkg::t_result             out_res;
    logic [jbl_pkg::RQ_CW-1:0]    q_count;

    // Room for two results is needed before the held byte is processed.
    assign fire          = r_in_valid && (q_count <= jbl_pkg::RQ_CW'(jbl_pkg::RQ_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tuser;
        end
    end

    jbl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_res   (core_res),
        .o_cnt   (core_cnt)
    );

    jbl_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? core_cnt : 2'd0),
        .i_res      (core_res),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res),
        .o_count    (q_count)
    );

    assign m_axis_tdata = {2'b00, out_res.error_code, out_res.bool_value,
                           out_res.number_kind, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= jbl_pkg::RQ_CW'(jbl_pkg::RQ_DEPTH))
        else $error("result queue overflow");

    a_doc_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == jbl_pkg::K_DOC_END) |-> m_axis_tlast)
        else $error("doc_end not marked as last result");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != jbl_pkg::K_STR_CHAR &&
         m_axis_tuser != jbl_pkg::K_NUM_CHAR) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("data byte set on a non-character result");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid) |=> ($past(q_count) >= q_count))
        else $error("results written without a held byte");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import jbl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 950;
    localparam int LONG_HOLD      = 80;
    localparam int HOLD_AT_RESULT = 300;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct {
        logic [7:0] b;
        logic       e;
        bit         typed;
        t_result    res;
    } t_dir_row;

    typedef struct {
        logic [7:0] b;
        logic       e;
    } t_byte_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tuser  = 1'b0;    // [0] end_mark
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] data_byte, [9:8] number_kind,
                                          // [10] bool_value, [13:11] error_code
    logic [3:0]  m_axis_tuser;            // [3:0] kind
    logic        m_axis_tlast;

    json_byte_lexer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lexer state as the testbench tracks it.
    t_mode      lx_mode = M_IDLE;
    logic [1:0] lx_sel  = L_TRUE;
    logic [2:0] lx_pos  = '0;
    t_num       nm      = '0;

    t_result    step_tokens[$];
    t_result    exp_tokens[$];
    t_dir_row   dir_tab[$];
    t_byte_item rand_items[$];
    int         rand_count  = 0;
    int         err_count   = 0;
    int         idle_cycles = 0;
    bit         src_burst   = 1'b0;

    function automatic void add_token(t_kind k, logic [7:0] d, logic [1:0] nk, logic bv,
                                      logic [2:0] ec);
        t_result r;
        r.kind        = k;
        r.data_byte   = d;
        r.number_kind = nk;
        r.bool_value  = bv;
        r.error_code  = ec;
        r.last        = 1'b0;
        step_tokens.insert(step_tokens.size(), r);
    endfunction

    function automatic void lex_num_char(logic [7:0] c);
        logic bad;
        bad = 1'b0;
        if (c == "+") begin
            if (nm.len == 0) nm.sign = 1'b1;
            else if (nm.prev != "e" && nm.prev != "E") bad = 1'b1;
        end else if (c == "-") begin
            if (nm.len == 0) nm.sign = 1'b1;
        end else if (c == ".") begin
            if (nm.point) bad = 1'b1;
            nm.point = 1'b1;
        end else if (c == "e" || c == "E") begin
            if (nm.expo) bad = 1'b1;
            nm.expo = 1'b1;
        end
        if (bad) begin
            nm = '0;
            lx_mode = M_IDLE;
            add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_NUMBER);
        end else begin
            if (nm.len == 0) nm.first_zero = (c == "0");
            if (nm.len == 1) nm.second_zero = (c == "0");
            if (nm.len < 3) nm.len = nm.len + 2'd1;
            nm.prev = c;
            add_token(K_NUM_CHAR, c, NK_UNSIGNED, 1'b0, ERR_START);
        end
    endfunction

    function automatic void lex_num_end();
        logic       bad;
        logic [1:0] nk;
        bad = nm.sign ? (nm.len <= 1) : (nm.len == 0);
        if (!bad && nm.point) begin
            nk = NK_REAL;
        end else if (nm.sign) begin
            if (nm.len >= 3 && nm.second_zero) bad = 1'b1;
            nk = NK_SIGNED;
        end else begin
            if (nm.len >= 2 && nm.first_zero) bad = 1'b1;
            nk = NK_UNSIGNED;
        end
        nm = '0;
        lx_mode = M_IDLE;
        if (bad) add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_NUMBER);
        else add_token(K_NUM_END, 8'h00, nk, 1'b0, ERR_START);
    endfunction

    function automatic void lex_token_start(logic [7:0] c);
        lx_mode = M_IDLE;
        case (c)
            " ", CH_TAB, CH_LF, CH_CR: ;
            "{": add_token(K_OBJ_BEGIN, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            "}": add_token(K_OBJ_END, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            "[": add_token(K_ARR_BEGIN, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            "]": add_token(K_ARR_END, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            ":": add_token(K_COLON, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            ",": add_token(K_COMMA, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            CH_QUOTE: begin
                lx_mode = M_STR;
                add_token(K_STR_START, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            end
            "t", "f", "n": begin
                lx_mode = M_LIT;
                lx_sel  = (c == "t") ? L_TRUE : (c == "f") ? L_FALSE : L_NULL;
                lx_pos  = 3'd1;
            end
            default: begin
                if (c == "-" || (c >= "0" && c <= "9")) begin
                    nm = '0;
                    lx_mode = M_NUM;
                    lex_num_char(c);
                end else begin
                    add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
                end
            end
        endcase
    endfunction

    function automatic void lex_escape(logic [7:0] c);
        lx_mode = M_STR;
        case (c)
            CH_QUOTE:  add_token(K_STR_CHAR, CH_QUOTE, NK_UNSIGNED, 1'b0, ERR_START);
            CH_BSLASH: add_token(K_STR_CHAR, CH_BSLASH, NK_UNSIGNED, 1'b0, ERR_START);
            "/":       add_token(K_STR_CHAR, "/", NK_UNSIGNED, 1'b0, ERR_START);
            "b":       add_token(K_STR_CHAR, CH_BS, NK_UNSIGNED, 1'b0, ERR_START);
            "f":       add_token(K_STR_CHAR, CH_FF, NK_UNSIGNED, 1'b0, ERR_START);
            "n":       add_token(K_STR_CHAR, CH_LF, NK_UNSIGNED, 1'b0, ERR_START);
            "r":       add_token(K_STR_CHAR, CH_CR, NK_UNSIGNED, 1'b0, ERR_START);
            "t":       add_token(K_STR_CHAR, CH_TAB, NK_UNSIGNED, 1'b0, ERR_START);
            "u":       ;
            default: begin
                lx_mode = M_IDLE;
                add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_ESCAPE);
            end
        endcase
    endfunction

    function automatic void lex_literal(logic [7:0] c);
        logic [39:0] txt;
        int          len;
        int          p;
        len = (lx_sel == L_FALSE) ? 5 : 4;
        case (lx_sel)
            L_TRUE:  txt = {"true", 8'h00};
            L_FALSE: txt = "false";
            default: txt = {"null", 8'h00};
        endcase
        p = int'(lx_pos);
        if (p >= len || txt[39 - 8 * p -: 8] != c) begin
            lx_mode = M_IDLE;
            lx_pos  = '0;
            add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_LITERAL);
        end else begin
            p = p + 1;
            lx_pos = p[2:0];
            if (p == len) begin
                lx_mode = M_IDLE;
                lx_pos  = '0;
                if (lx_sel == L_TRUE)
                    add_token(K_BOOLEAN, 8'h00, NK_UNSIGNED, 1'b1, ERR_START);
                else if (lx_sel == L_FALSE)
                    add_token(K_BOOLEAN, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
                else
                    add_token(K_NULL, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
            end
        end
    endfunction

    // Fills step_tokens with the results one accepted byte causes.
    function automatic void lex_step(logic [7:0] c, logic e);
        step_tokens.delete();
        if (e) begin
            case (lx_mode)
                M_STR, M_ESC: add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_UNTERM);
                M_NUM:        lex_num_end();
                M_LIT:        add_token(K_ERROR, 8'h00, NK_UNSIGNED, 1'b0, ERR_LITERAL);
                default:      ;
            endcase
            lx_mode = M_IDLE;
            lx_pos  = '0;
            add_token(K_DOC_END, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
        end else begin
            case (lx_mode)
                M_STR: begin
                    if (c == CH_BSLASH) begin
                        lx_mode = M_ESC;
                    end else if (c == CH_QUOTE) begin
                        lx_mode = M_IDLE;
                        add_token(K_STR_END, 8'h00, NK_UNSIGNED, 1'b0, ERR_START);
                    end else begin
                        add_token(K_STR_CHAR, c, NK_UNSIGNED, 1'b0, ERR_START);
                    end
                end
                M_ESC: lex_escape(c);
                M_NUM: begin
                    if ((c >= "0" && c <= "9") || c == "+" || c == "-" || c == "." ||
                        c == "e" || c == "E") begin
                        lex_num_char(c);
                    end else begin
                        // The delimiter that closes a number starts the next token.
                        lex_num_end();
                        lex_token_start(c);
                    end
                end
                M_LIT: lex_literal(c);
                default: lex_token_start(c);
            endcase
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic void dir_row(logic [7:0] b, logic e = 1'b0, bit typed = 1'b0,
                                    t_kind k = K_ERROR, logic [2:0] ec = ERR_START,
                                    logic bv = 1'b0);
        t_dir_row row;
        row.b     = b;
        row.e     = e;
        row.typed = typed;
        row.res   = '0;
        row.res.kind       = k;
        row.res.error_code = ec;
        row.res.bool_value = bv;
        row.res.last       = 1'b1;
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    function automatic void push_item(logic [7:0] b, logic e = 1'b0);
        t_byte_item it;
        it.b = b;
        it.e = e;
        rand_items.insert(rand_items.size(), it);
        rand_count++;
    endfunction

    function automatic void push_word(string w);
        for (int i = 0; i < w.len(); i++) push_item(w[i]);
    endfunction

    function automatic logic [7:0] rand_digit(int lo);
        return 8'h30 + 8'($urandom_range(lo, 9));
    endfunction

    function automatic void gen_string();
        int         n;
        logic [7:0] c;
        push_item(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 9))
                7: begin
                    push_item(CH_BSLASH);
                    case ($urandom_range(0, 7))
                        0: push_item(CH_QUOTE);
                        1: push_item(CH_BSLASH);
                        2: push_item("/");
                        3: push_item("b");
                        4: push_item("f");
                        5: push_item("n");
                        6: push_item("r");
                        default: push_item("t");
                    endcase
                end
                8: begin
                    push_word("\\u");
                    repeat (4) push_item($urandom_range(0, 1) ? rand_digit(0) : "a");
                end
                9: begin
                    if ($urandom_range(0, 2) == 0) begin
                        push_item(CH_BSLASH);
                        push_item(8'($urandom_range(0, 255)));
                    end else begin
                        push_item(8'($urandom_range(8'h20, 8'h7E)));
                    end
                end
                default: begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
                    push_item(c);
                end
            endcase
        end
        if ($urandom_range(0, 19) == 0) push_item(8'($urandom_range(0, 255)), 1'b1);
        else push_item(CH_QUOTE);
    endfunction

    function automatic void gen_number();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            // Loose run of number characters, mostly malformed.
            n = $urandom_range(1, 4);
            repeat (n) begin
                case ($urandom_range(0, 14))
                    10: push_item("+");
                    11: push_item("-");
                    12: push_item(".");
                    13: push_item("e");
                    14: push_item("E");
                    default: push_item(rand_digit(0));
                endcase
            end
        end else begin
            if ($urandom_range(0, 1)) push_item("-");
            if ($urandom_range(0, 4) == 0) begin
                push_item("0");
                if ($urandom_range(0, 3) == 0) push_item(rand_digit(0));
            end else begin
                push_item(rand_digit(1));
                n = $urandom_range(0, 2);
                repeat (n) push_item(rand_digit(0));
            end
            if ($urandom_range(0, 2) == 0) begin
                push_item(".");
                n = $urandom_range(1, 2);
                repeat (n) push_item(rand_digit(0));
            end
            if ($urandom_range(0, 3) == 0) begin
                push_item($urandom_range(0, 1) ? "e" : "E");
                if ($urandom_range(0, 1)) push_item($urandom_range(0, 1) ? "+" : "-");
                n = $urandom_range(1, 2);
                repeat (n) push_item(rand_digit(0));
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 5))
                0: push_item(",");
                1: push_item("]");
                2: push_item("}");
                3: push_item(":");
                4: push_item(CH_LF);
                default: push_item(" ");
            endcase
        end
    endfunction

    function automatic void gen_literal();
        string w;
        int    n;
        case ($urandom_range(0, 2))
            0: w = "true";
            1: w = "false";
            default: w = "null";
        endcase
        if ($urandom_range(0, 6) == 0) begin
            // Cut the word short and follow it with an arbitrary byte.
            n = $urandom_range(1, w.len() - 1);
            for (int i = 0; i < n; i++) push_item(w[i]);
            push_item(8'($urandom_range(0, 255)));
        end else begin
            push_word(w);
        end
    endfunction

    function automatic void gen_token();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 16, 17: begin
                case ($urandom_range(0, 5))
                    0: push_item("{");
                    1: push_item("}");
                    2: push_item("[");
                    3: push_item("]");
                    4: push_item(":");
                    default: push_item(",");
                endcase
            end
            4, 5: begin
                case ($urandom_range(0, 3))
                    0: push_item(" ");
                    1: push_item(CH_TAB);
                    2: push_item(CH_LF);
                    default: push_item(CH_CR);
                endcase
            end
            6, 7, 8: gen_string();
            9, 10, 11, 18: gen_number();
            12, 13, 19: gen_literal();
            14: push_item(8'($urandom_range(0, 255)));
            default: push_item(8'($urandom_range(0, 255)), 1'b1);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                             input t_result tres);
        int gap;
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= e;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // The transfer took place at this edge.
        lex_step(b, e);
        if (typed) begin
            step_tokens.delete();
            step_tokens.insert(0, tres);
        end
        foreach (step_tokens[i]) exp_tokens.insert(exp_tokens.size(), step_tokens[i]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_tokens.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_result no_res;
        no_res = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_row(8'hFF, 1'b1, 1'b1, K_DOC_END);
        dir_row("{", 1'b0, 1'b1, K_OBJ_BEGIN);
        dir_row(" ");
        dir_row(CH_QUOTE, 1'b0, 1'b1, K_STR_START);
        dir_row("a");
        dir_row(CH_BSLASH);
        dir_row("n");
        dir_row(CH_BSLASH);
        dir_row("u");
        dir_row("0");
        dir_row(CH_BSLASH);
        dir_row("q", 1'b0, 1'b1, K_ERROR, ERR_ESCAPE);
        dir_row(":", 1'b0, 1'b1, K_COLON);
        dir_row("-");
        dir_row("0");
        dir_row("1");
        dir_row(",");
        dir_row("t");
        dir_row("r");
        dir_row("u");
        dir_row("e", 1'b0, 1'b1, K_BOOLEAN, ERR_START, 1'b1);
        dir_row("n");
        dir_row("x", 1'b0, 1'b1, K_ERROR, ERR_LITERAL);
        dir_row(8'h00, 1'b0, 1'b1, K_ERROR, ERR_START);
        dir_row(8'hFF, 1'b0, 1'b1, K_ERROR, ERR_START);
        dir_row("5");
        dir_row("+", 1'b0, 1'b1, K_ERROR, ERR_NUMBER);
        dir_row("7");
        dir_row(8'h00, 1'b1);
        dir_row(CH_QUOTE);
        dir_row(8'h00, 1'b1);

        foreach (dir_tab[i])
            send_byte(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].res);
        wait_drained();

        while (rand_count < RANDOM_ITEMS) gen_token();
        foreach (rand_items[i]) send_byte(rand_items[i].b, rand_items[i].e, 1'b0, no_res);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin : result_sink
        int  hold;
        int  taken;
        bit  burst;
        taken = 0;
        burst = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            if (taken == HOLD_AT_RESULT) hold = LONG_HOLD;
            else hold = burst ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_tokens.size() == 0) begin
                $error("result with no expectation: kind %0d", m_axis_tuser);
                err_count++;
            end else begin
                want = exp_tokens.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
                check_field("number_kind", want.number_kind, m_axis_tdata[9:8]);
                check_field("bool_value", want.bool_value, m_axis_tdata[10]);
                check_field("error_code", want.error_code, m_axis_tdata[13:11]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule

// ===== files.f =====
sv/jbl_pkg.sv
sv/jbl_core.sv
sv/jbl_res_fifo.sv
sv/json_byte_lexer_unit.sv
sim/tb.sv
